/* rtl/core/mt19937_random_draws_assert.svh */
// ----------------------------------------------------------------------------
// mt19937_random_draws assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MT19937_RANDOM_DRAWS_ASSERT_SVH
`define MT19937_RANDOM_DRAWS_ASSERT_SVH

`ifndef SYNTHESIS
`define MTRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MTRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTRD_ASSERT(label, prop, msg)
`define MTRD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/mtrd_pkg.sv */
// ----------------------------------------------------------------------------
// mtrd_pkg
// Shared types, constants and the tempering function of the MT19937 block.
// ----------------------------------------------------------------------------
package mtrd_pkg;

    localparam int unsigned N_WORDS  = 624;
    localparam int unsigned M_OFFSET = 397;
    localparam int unsigned ADDR_W   = $clog2(N_WORDS);
    localparam int unsigned DRAW_W   = 31;
    localparam int unsigned VALUE_W  = 62;

    localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
    localparam logic [31:0] UPPER_MASK = 32'h80000000;
    localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] SEED_RESET = 32'd5489;

    typedef logic [ADDR_W-1:0] word_addr_t;

    typedef enum logic [1:0] {
        OP_DRAW31 = 2'd0,
        OP_DRAW62 = 2'd1,
        OP_MOD    = 2'd2
    } op_t;

    typedef struct packed {
        logic        en;
        word_addr_t  addr;
        logic [31:0] data;
    } mtrd_wr_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

/* rtl/core/mt19937_random_draws.sv */
// ----------------------------------------------------------------------------
// mt19937_random_draws: MT19937 generator with 31-bit, 62-bit and modulo draws
// A modulo draw goes through the remainder unit, but a zero bound passes the word
// through unreduced; an unused op code returns zero.
// One request at a time; the next is taken in the cycle the result goes valid.
// Each state word a draw uses is regenerated in place: three reads, then one write.
// After reset or a seed write the state is filled anew; requests stall meanwhile.
// ----------------------------------------------------------------------------
module mt19937_random_draws
    import mtrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [31:0]        seed,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [DRAW_W-1:0]  bound,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VALUE_W-1:0] value
);

    typedef enum logic [3:0] {
        ST_SEED0,
        ST_SMUL,
        ST_SWR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_TW,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        seed_reg, seed_next;
    word_addr_t         idx_reg, idx_next;
    logic [31:0]        prev_reg, prev_next;
    logic [31:0]        prod_reg, prod_next;
    logic [31:0]        wi_reg, wi_next;
    logic [31:0]        wi1_reg, wi1_next;
    logic [1:0]         op_reg, op_next;
    logic [DRAW_W-1:0]  bound_reg, bound_next;
    logic               second_reg, second_next;
    logic [DRAW_W-1:0]  lo_reg, lo_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               out_valid_reg, out_valid_next;

    mtrd_wr_t          mem_wr;
    word_addr_t        mem_rd_addr;
    logic [31:0]       mem_rd_data;
    logic              div_start;
    logic              div_done;
    logic [DRAW_W-1:0] div_rem;

    word_addr_t  idx_plus1;
    word_addr_t  idx_plus_m;
    logic [10:0] idx_m_sum;
    logic [31:0] mix;
    logic [31:0] seed_word;
    logic [31:0] y;
    logic [31:0] tw;
    logic [31:0] tempered;
    logic        out_free;

    mtrd_state_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mtrd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tempered),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        idx_plus1  = (idx_reg == ADDR_W'(N_WORDS - 1)) ? '0 : idx_reg + ADDR_W'(1);
        idx_m_sum  = {1'b0, idx_reg} + 11'(M_OFFSET);
        idx_plus_m = (idx_m_sum >= 11'(N_WORDS)) ? ADDR_W'(idx_m_sum - 11'(N_WORDS))
                                                  : idx_m_sum[ADDR_W-1:0];

        mix       = prev_reg ^ (prev_reg >> 30);
        seed_word = prod_reg + {{(32-ADDR_W){1'b0}}, idx_reg};

        // in-place twist: word i+1 still old except at the wrap, word i+397 already new past the wrap
        y        = (wi_reg & UPPER_MASK) | (wi1_reg & LOWER_MASK);
        tw       = mem_rd_data ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
        tempered = temper(tw);

        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        prod_next      = prod_reg;
        wi_next        = wi_reg;
        wi1_next       = wi1_reg;
        op_next        = op_reg;
        bound_next     = bound_reg;
        second_next    = second_reg;
        lo_next        = lo_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;

        mem_wr      = '0;
        mem_rd_addr = idx_reg;
        div_start   = 1'b0;

        case (state_reg)
            ST_SEED0:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = '0;
                mem_wr.data = seed_reg;
                prev_next   = seed_reg;
                idx_next    = ADDR_W'(1);
                state_next  = ST_SMUL;
            end
            ST_SMUL:
            begin
                prod_next  = INIT_MULT * mix;
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = idx_reg;
                mem_wr.data = seed_word;
                prev_next   = seed_word;
                if (idx_reg == ADDR_W'(N_WORDS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_SMUL;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    bound_next  = bound;
                    second_next = 1'b0;
                    case (op)
                        OP_DRAW31, OP_DRAW62, OP_MOD:
                        begin
                            state_next = ST_RD0;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RD0:
            begin
                mem_rd_addr = idx_reg;
                state_next  = ST_RD1;
            end
            ST_RD1:
            begin
                mem_rd_addr = idx_plus1;
                wi_next     = mem_rd_data;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                mem_rd_addr = idx_plus_m;
                wi1_next    = mem_rd_data;
                state_next  = ST_TW;
            end
            ST_TW:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = idx_reg;
                mem_wr.data = tw;
                idx_next    = idx_plus1;
                case (op_reg)
                    OP_DRAW31:
                    begin
                        res_next   = {{(VALUE_W-DRAW_W){1'b0}}, tempered[DRAW_W-1:0]};
                        state_next = ST_FIN;
                    end
                    OP_DRAW62:
                    begin
                        if (!second_reg)
                        begin
                            lo_next     = tempered[DRAW_W-1:0];
                            second_next = 1'b1;
                            state_next  = ST_RD0;
                        end
                        else
                        begin
                            res_next   = {tempered[DRAW_W-1:0], lo_reg};
                            state_next = ST_FIN;
                        end
                    end
                    OP_MOD:
                    begin
                        if (bound_reg == '0)
                        begin
                            res_next   = {{(VALUE_W-32){1'b0}}, tempered};
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = {{(VALUE_W-DRAW_W){1'b0}}, div_rem};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    value_next     = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new seed restarts the state fill
        if (seed_we)
        begin
            seed_next  = seed;
            state_next = ST_SEED0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED0;
            seed_reg      <= SEED_RESET;
            idx_reg       <= '0;
            op_reg        <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        prod_reg  <= prod_next;
        wi_reg    <= wi_next;
        wi1_reg   <= wi1_next;
        bound_reg <= bound_next;
        lo_reg    <= lo_next;
        res_reg   <= res_next;
        value_reg <= value_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

`include "mt19937_random_draws_assert.svh"

    `MTRD_ASSERT(a_idx_range, idx_reg < ADDR_W'(N_WORDS), "word index out of range")
    `MTRD_ASSERT(a_div_done_state, !div_done || (state_reg == ST_DIV), "divider done outside wait")
    `MTRD_ASSERT(a_narrow_result, !((state_reg == ST_FIN) && (op_reg != OP_DRAW62)) || (res_reg[VALUE_W-1:32] == '0), "upper result bits set")
    `MTRD_ASSERT_NEXT(a_out_drain, out_valid && !out_stall && (state_reg != ST_FIN), !out_valid, "result repeated")

endmodule

/* rtl/core/mtrd_state_mem.sv */
// ----------------------------------------------------------------------------
// mtrd_state_mem
// 624 x 32 twister state, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtrd_state_mem
    import mtrd_pkg::*;
(
    input  logic        clk,
    input  mtrd_wr_t    wr,
    input  word_addr_t  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [N_WORDS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/mtrd_divider.sv */
// ----------------------------------------------------------------------------
// mtrd_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtrd_divider
    import mtrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [DRAW_W-1:0] divisor,
    output logic              done,
    output logic [DRAW_W-1:0] remainder
);

    localparam int unsigned STEPS = 32;

    logic [31:0]       quo_reg, quo_next;
    logic [DRAW_W-1:0] rem_reg, rem_next;
    logic [DRAW_W-1:0] div_reg, div_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    logic [31:0] r_sh;
    logic [31:0] r_diff;
    logic        fits;

    always_comb
    begin
        r_sh   = {rem_reg, quo_reg[31]};
        fits   = r_sh >= {1'b0, div_reg};
        r_diff = r_sh - {1'b0, div_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so it fits in 31 bits
            rem_next = fits ? r_diff[DRAW_W-1:0] : r_sh[DRAW_W-1:0];
            quo_next = quo_reg << 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* verif/mt_draw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_draw_checker
// Watches the request, result and seed ports of the MT19937 draw block, keeps
// its own copy of the twister state and compares every accepted result with
// the value predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module mt_draw_checker
    import mtrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [31:0]        seed,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic [DRAW_W-1:0]  bound,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [VALUE_W-1:0] value,
    output int                 pending,
    output int                 errors
);

    logic [31:0]        mt_words [N_WORDS];
    int unsigned        mt_pos;
    logic [VALUE_W-1:0] expected_values [$];
    logic [VALUE_W-1:0] want;

    function automatic void reseed_words(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int unsigned i = 1; i < N_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = INIT_MULT * (p ^ (p >> 30)) + i;
        end
        mt_pos = N_WORDS;
    endfunction

    function automatic void regenerate_words();
        logic [31:0] y;
        logic [31:0] v;
        for (int unsigned i = 0; i < N_WORDS; i++)
        begin
            y = (mt_words[i] & UPPER_MASK) | (mt_words[(i + 1) % N_WORDS] & LOWER_MASK);
            v = mt_words[(i + M_OFFSET) % N_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ MATRIX_A;
            mt_words[i] = v;
        end
        mt_pos = 0;
    endfunction

    // one tempered 32-bit output, twisting first when the state is used up
    function automatic logic [31:0] pull_draw();
        logic [31:0] y;
        if (mt_pos >= N_WORDS)
            regenerate_words();
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [VALUE_W-1:0] predict_value(input logic [1:0] req_op,
                                                         input logic [DRAW_W-1:0] req_bound);
        logic [31:0]        a;
        logic [31:0]        b;
        logic [VALUE_W-1:0] v;
        v = '0;
        case (req_op)
            OP_DRAW31:
            begin
                a = pull_draw();
                v = {31'b0, a[30:0]};
            end
            OP_DRAW62:
            begin
                a = pull_draw();
                b = pull_draw();
                v = {b[30:0], a[30:0]};
            end
            OP_MOD:
            begin
                a = pull_draw();
                // zero bound passes the draw through unreduced
                if (req_bound == '0)
                    v = {30'b0, a};
                else
                    v = {30'b0, a % {1'b0, req_bound}};
            end
            default:
                v = '0;
        endcase
        return v;
    endfunction

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reseed_words(SEED_RESET);
            expected_values.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                    flag_error($sformatf("unexpected result %h with no request pending", value));
                else
                begin
                    want = expected_values.pop_front();
                    if (want !== value)
                        flag_error($sformatf("value mismatch: expected %h, got %h", want, value));
                end
            end
            if (in_valid && !in_stall)
                expected_values.push_back(predict_value(op, bound));
            if (seed_we)
                reseed_words(seed);
            pending = expected_values.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the MT19937 draw block with directed and random requests under
// several seeds and idle patterns, including a long output hold-off, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
    import mtrd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_ITEMS = 630;
    localparam int         HOLD_CYCLES = 600;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               seed_we;
    logic [31:0]        seed;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [DRAW_W-1:0]  bound;
    logic               out_valid;
    logic               out_stall;
    logic [VALUE_W-1:0] value;

    int pending;
    int errors;
    int send_idle;
    int recv_idle;
    bit hold_req = 1'b0;
    bit hold_ack;
    int hold_left;
    int op_count [4];
    int seeds_written;

    mt19937_random_draws dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed      (seed),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    mt_draw_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed      (seed),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .bound     (bound),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        hold_ack  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    initial
    begin
        #(10_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // returns in the time step of the edge that accepted the request
    task automatic push_request(input logic [1:0] req_op, input logic [DRAW_W-1:0] req_bound);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        bound    <= req_bound;
        op_count[req_op]++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_seed(input logic [31:0] s);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        seed_we <= 1'b1;
        seed    <= s;
        @(negedge clk);
        seed_we <= 1'b0;
        seeds_written++;
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return OP_DRAW31;
        if (r < 55)
            return OP_DRAW62;
        if (r < 95)
            return OP_MOD;
        return OP_UNUSED;
    endfunction

    function automatic logic [DRAW_W-1:0] pick_bound();
        logic [DRAW_W-1:0] b;
        case ($urandom_range(9))
            0: b = '0;
            1: b = 31'd1;
            2: b = '1;
            3: b = DRAW_W'($urandom_range(16, 2));
            4: b = 31'd1 << $urandom_range(30);
            5: b = (31'd1 << $urandom_range(30, 1)) - 31'd1;
            default: b = DRAW_W'($urandom());
        endcase
        return b;
    endfunction

    task automatic run_phase(input int n, input bit with_hold);
        for (int k = 0; k < n; k++)
        begin
            push_request(pick_op(), pick_bound());
            if (with_hold && k == 100)
                hold_req = ~hold_req;
        end
    endtask

    initial
    begin
        int waited;
        rst_n         = 1'b0;
        seed_we       = 1'b0;
        seed          = SEED_RESET;
        in_valid      = 1'b0;
        op            = OP_DRAW31;
        bound         = '0;
        seeds_written = 0;
        send_idle     = 26;
        recv_idle     = 49;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: every op, bound extremes, zero bound, unused op code
        push_request(OP_DRAW31, '0);
        push_request(OP_DRAW62, '0);
        push_request(OP_MOD,    31'd1);
        push_request(OP_MOD,    '1);
        push_request(OP_MOD,    '0);
        push_request(OP_UNUSED, '0);
        push_request(OP_MOD,    31'd2);
        push_request(OP_MOD,    31'h40000000);
        push_request(OP_MOD,    31'h55555555);
        push_request(OP_MOD,    31'h2aaaaaaa);
        push_request(OP_DRAW62, '1);
        push_request(OP_DRAW31, '1);
        push_request(OP_UNUSED, '1);
        push_request(OP_MOD,    31'd3);
        push_request(OP_MOD,    31'h40000001);
        push_request(OP_DRAW31, 31'h12345678);

        write_seed(32'h0);
        run_phase(PHASE_ITEMS, 1'b0);

        send_idle = 49;
        recv_idle = 26;
        write_seed(32'hffffffff);
        run_phase(PHASE_ITEMS, 1'b1);

        send_idle = 0;
        recv_idle = 0;
        write_seed($urandom());
        run_phase(PHASE_ITEMS, 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (60) @(negedge clk);

        $display("covered %0d requests: %0d 31-bit, %0d 62-bit, %0d modulo, %0d unused op",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("reset seed plus %0d seed writes (zero, all ones, random), one %0d-cycle hold-off",
                 seeds_written, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
